// ===== sv/abpd_pkg.sv =====
// abpd_pkg: shared types, constants and AES helper functions for the packet decoder.
// Depends on nothing.
package abpd_pkg;

   typedef logic [127:0] block_type;
   typedef logic [0:10][127:0] key_sched_type;
   typedef logic [255:0][7:0] byte_table_type;

   localparam int Rounds = 10;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_BAD_VALUE  = 2'd2
   } status_type;

   localparam logic [7:0] HDR_BYTE0 = 8'hd1;
   localparam logic [7:0] HDR_BYTE1 = 8'h55;
   localparam logic [7:0] HDR_BYTE2 = 8'h07;
   localparam logic [7:0] CHARGE_MAX = 8'd100;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] t;
      p = '0;
      t = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ t;
         t = xtime(t);
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] b;
      r = 8'd1;
      b = x;
      for (int i = 0; i < 8; i++) begin
         if (i != 0) r = gf_mul(r, b);
         b = gf_mul(b, b);
      end
      return r;
   endfunction

   // Forward S-box, only evaluated while building the constant tables.
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] b;
      b = gf_inv(x);
      return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
             ^ 8'h63;
   endfunction

   function automatic byte_table_type build_inv_sbox();
      byte_table_type tab;
      logic [7:0] s;
      tab = '0;
      for (int x = 0; x < 256; x++) begin
         s = sbox(x[7:0]);
         tab[s] = x[7:0];
      end
      return tab;
   endfunction

   function automatic key_sched_type expand_key(input block_type key);
      key_sched_type ks;
      logic [43:0][31:0] w;
      logic [31:0] t;
      logic [7:0] rcon;
      rcon = 8'h01;
      w = '0;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sbox(t[23:16]) ^ rcon, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
            rcon = xtime(rcon);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) ks[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      return ks;
   endfunction

   localparam block_type AES_KEY = 128'h6c656167656e64fffe30313030303039;

   // Inverse S-box as a constant lookup table.
   localparam byte_table_type INV_SBOX = build_inv_sbox();

   // Expanded round keys, round 0 first; byte 0 in bits 127:120.
   localparam key_sched_type ROUND_KEY = expand_key(AES_KEY);

   function automatic logic [7:0] inv_sbox(input logic [7:0] s);
      return INV_SBOX[s];
   endfunction

   function automatic logic [7:0] blk_byte(input block_type b, input int n);
      return b[127-8*n -: 8];
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      t = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(blk_byte(s, 4*c+r));
      return t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = blk_byte(s, 4*c);
         a1 = blk_byte(s, 4*c+1);
         a2 = blk_byte(s, 4*c+2);
         a3 = blk_byte(s, 4*c+3);
         t[127-32*c -: 8]  = gf_mul(a0,8'd14)^gf_mul(a1,8'd11)^gf_mul(a2,8'd13)^gf_mul(a3,8'd9);
         t[119-32*c -: 8]  = gf_mul(a0,8'd9)^gf_mul(a1,8'd14)^gf_mul(a2,8'd11)^gf_mul(a3,8'd13);
         t[111-32*c -: 8]  = gf_mul(a0,8'd13)^gf_mul(a1,8'd9)^gf_mul(a2,8'd14)^gf_mul(a3,8'd11);
         t[103-32*c -: 8]  = gf_mul(a0,8'd11)^gf_mul(a1,8'd13)^gf_mul(a2,8'd9)^gf_mul(a3,8'd14);
      end
      return t;
   endfunction

endpackage

// ===== sv/aes128_battery_packet_decoder_core.sv =====
// Pipelined AES-128 packet decoder: one transaction may enter every cycle unless req_stall
// is high. From the accepting edge to rsp_valid the data passes one key-add input register,
// ten registered inverse-round stages and one output register with the field
// decode. The whole pipe advances together; rsp_stall holds every stage, and
// req_stall follows it only when the output register is full.
module aes128_battery_packet_decoder_core
   import abpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_cipher_word0,
   input  logic [31:0] req_cipher_word1,
   input  logic [31:0] req_cipher_word2,
   input  logic [31:0] req_cipher_word3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic signed [8:0] rsp_temperature_c,
   output logic [7:0]  rsp_charge_percent,
   output logic [15:0] rsp_voltage_centivolts
);

   logic      advance;
   logic      v [0:Rounds];
   block_type d [0:Rounds];
   logic      in_valid_ff;
   block_type in_data_ff;
   logic      out_valid_ff;
   logic [1:0] status_ff;
   logic signed [8:0] temp_ff;
   logic [7:0]  charge_ff;
   logic [15:0] volt_ff;
   status_type  st_in;
   logic signed [8:0] temp_in;
   logic [7:0]  charge_in;
   logic [15:0] volt_in;

   // bubbles ahead collapse only through the whole-pipe advance
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) in_data_ff <= {req_cipher_word0, req_cipher_word1,
                                  req_cipher_word2, req_cipher_word3} ^ ROUND_KEY[Rounds];
   end

   assign v[Rounds] = in_valid_ff;
   assign d[Rounds] = in_data_ff;

   for (genvar r = 0; r < Rounds; r++) begin : g_round
      abpd_round #(.RoundIdx(r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v[r+1]),
         .in_data   (d[r+1]),
         .out_valid (v[r]),
         .out_data  (d[r])
      );
   end

   abpd_field u_field (
      .plain              (d[0]),
      .status             (st_in),
      .temperature_c      (temp_in),
      .charge_percent     (charge_in),
      .voltage_centivolts (volt_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= v[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= st_in;
         temp_ff   <= temp_in;
         charge_ff <= charge_in;
         volt_ff   <= volt_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_temperature_c      = temp_ff;
   assign rsp_charge_percent     = charge_ff;
   assign rsp_voltage_centivolts = volt_ff;

endmodule

// ===== sv/abpd_round.sv =====
// abpd_round: one registered inverse AES round with its valid bit.
// Depends on abpd_pkg.
module abpd_round
   import abpd_pkg::*;
#(
   parameter int RoundIdx = 9
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  block_type in_data,
   output logic      out_valid,
   output block_type out_data
);

   logic      valid_ff;
   block_type data_ff;
   block_type data_in;

   always_comb begin
      data_in = inv_shift_sub(in_data) ^ ROUND_KEY[RoundIdx];
      if (RoundIdx != 0) data_in = inv_mix(data_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/abpd_field.sv =====
// abpd_field: header check and field extraction from a plaintext block.
// Depends on abpd_pkg.
module abpd_field
   import abpd_pkg::*;
(
   input  block_type   plain,
   output status_type  status,
   output logic signed [8:0] temperature_c,
   output logic [7:0]  charge_percent,
   output logic [15:0] voltage_centivolts
);

   logic [7:0] b3, b4;

   always_comb begin
      b3 = blk_byte(plain, 3);
      b4 = blk_byte(plain, 4);
      status             = STATUS_OK;
      temperature_c      = '0;
      charge_percent     = '0;
      voltage_centivolts = '0;
      if (blk_byte(plain, 0) != HDR_BYTE0 || blk_byte(plain, 1) != HDR_BYTE1 ||
          blk_byte(plain, 2) != HDR_BYTE2) begin
         status = STATUS_BAD_HEADER;
      end else begin
         temperature_c      = (b3 == 8'd1) ? -$signed({1'b0, b4}) : $signed({1'b0, b4});
         charge_percent     = blk_byte(plain, 6);
         voltage_centivolts = {blk_byte(plain, 7), blk_byte(plain, 8)};
         if (voltage_centivolts == 16'd0 || charge_percent > CHARGE_MAX)
            status = STATUS_BAD_VALUE;
      end
   end

endmodule

// ===== sv/abpd_checker.sv =====
// abpd_checker: port-level checks on the packet decoder, bound to the top level.
// Depends on abpd_pkg and aes128_battery_packet_decoder_core.
module abpd_checker
   import abpd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_charge_percent,
   input logic [15:0] rsp_voltage_centivolts
);

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("input stalled while output free");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("illegal status code");

   a_header_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_HEADER |->
      rsp_charge_percent == 8'd0 && rsp_voltage_centivolts == 16'd0)
      else $error("fields not cleared on header mismatch");

   a_ok_is_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
      rsp_voltage_centivolts != 16'd0 && rsp_charge_percent <= CHARGE_MAX)
      else $error("ok status with bad reading");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind aes128_battery_packet_decoder_core abpd_checker u_abpd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_status             (rsp_status),
   .rsp_charge_percent     (rsp_charge_percent),
   .rsp_voltage_centivolts (rsp_voltage_centivolts)
);
